@@ sv/integer_alu_div_mulh_bitcount_unit_assert.svh @@
// Assertion macros used by the checker file of the integer ALU.
`ifndef INTEGER_ALU_DIV_MULH_BITCOUNT_UNIT_ASSERT_SVH
`define INTEGER_ALU_DIV_MULH_BITCOUNT_UNIT_ASSERT_SVH
// Clocked assertion, ignored while reset is held.
`define IADMB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iadmb assertion failed");
// Clocked assertion that is also checked during reset.
`define IADMB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("iadmb assertion failed");
`endif

@@ sv/iadmb_pkg.sv @@
// Package: types, opcodes and pipeline constants of the integer ALU.
`timescale 1ns / 1ps
package iadmb_pkg;

    localparam int DATA_W    = 64;
    localparam int DIV_STEPS = DATA_W;
    localparam int MUL_LAT   = 4;

    localparam logic [4:0] OP_DIV32    = 5'd0;
    localparam logic [4:0] OP_REM32    = 5'd1;
    localparam logic [4:0] OP_DIVU32   = 5'd2;
    localparam logic [4:0] OP_REMU32   = 5'd3;
    localparam logic [4:0] OP_SHL      = 5'd4;
    localparam logic [4:0] OP_SHR      = 5'd5;
    localparam logic [4:0] OP_SAR      = 5'd6;
    localparam logic [4:0] OP_DIV64    = 5'd7;
    localparam logic [4:0] OP_REM64    = 5'd8;
    localparam logic [4:0] OP_DIVU64   = 5'd9;
    localparam logic [4:0] OP_REMU64   = 5'd10;
    localparam logic [4:0] OP_MULHU    = 5'd11;
    localparam logic [4:0] OP_MULHS    = 5'd12;
    localparam logic [4:0] OP_CLZ32    = 5'd13;
    localparam logic [4:0] OP_CTZ32    = 5'd14;
    localparam logic [4:0] OP_CLZ64    = 5'd15;
    localparam logic [4:0] OP_CTZ64    = 5'd16;
    localparam logic [4:0] OP_CLRSB32  = 5'd17;
    localparam logic [4:0] OP_CLRSB64  = 5'd18;
    localparam logic [4:0] OP_POPCNT32 = 5'd19;
    localparam logic [4:0] OP_POPCNT64 = 5'd20;

    typedef struct packed {
        logic [4:0]        opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              divide_by_zero;
    } rsp_t;

    // State of one restoring divide step.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dq;
        logic [DATA_W-1:0] d;
    } div_t;

    typedef enum logic [1:0] {
        SEL_QUO,
        SEL_REM,
        SEL_MUL,
        SEL_MISC
    } sel_t;

    // Control that rides alongside the divider.
    typedef struct packed {
        sel_t              sel;
        logic              neg_q;
        logic              neg_r;
        logic              is32;
        logic              dz;
        logic [DATA_W-1:0] misc;
    } tag_t;

endpackage

@@ sv/iadmb_div_step.sv @@
// One registered stage of the restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module iadmb_div_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  iadmb_pkg::div_t in_div,
    output logic            out_valid,
    output iadmb_pkg::div_t out_div
);
    import iadmb_pkg::*;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;
    div_t              div_next;
    logic              valid_reg;
    div_t              div_reg;

    always_comb
    begin
        trial    = {in_div.rem, in_div.dq[DATA_W-1]};
        diff     = trial - {1'b0, in_div.d};
        fits     = !diff[DATA_W];
        div_next.d   = in_div.d;
        div_next.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        div_next.dq  = {in_div.dq[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
endmodule

@@ sv/iadmb_mul.sv @@
// Four-stage pipelined high half of the 64x64 product, signed or unsigned.
`timescale 1ns / 1ps
module iadmb_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [iadmb_pkg::DATA_W-1:0] a,
    input  logic [iadmb_pkg::DATA_W-1:0] b,
    input  logic                        is_signed,
    output logic [iadmb_pkg::DATA_W-1:0] high
);
    import iadmb_pkg::*;

    localparam int H = DATA_W / 2;

    logic [DATA_W-1:0] a1_reg, b1_reg, ll1_reg, lh1_reg;
    logic              s1_reg;
    logic [DATA_W-1:0] a2_reg, b2_reg, ll2_reg, lh2_reg, hl2_reg, hh2_reg;
    logic              s2_reg;
    logic [DATA_W-1:0] a3_reg, b3_reg, hi3_reg;
    logic              s3_reg;
    logic [DATA_W-1:0] hi4_reg;
    logic [H+1:0]      mid;
    logic [DATA_W-1:0] hi_next;
    logic [DATA_W-1:0] hi4_next;

    always_comb
    begin
        mid = {2'b00, ll2_reg[DATA_W-1:H]} + {2'b00, lh2_reg[H-1:0]}
            + {2'b00, hl2_reg[H-1:0]};
        hi_next = hh2_reg + {{H{1'b0}}, lh2_reg[DATA_W-1:H]}
                + {{H{1'b0}}, hl2_reg[DATA_W-1:H]}
                + {{(DATA_W-2){1'b0}}, mid[H+1:H]};
        hi4_next = hi3_reg - ((s3_reg && a3_reg[DATA_W-1]) ? b3_reg : '0)
                           - ((s3_reg && b3_reg[DATA_W-1]) ? a3_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a;
            b1_reg  <= b;
            s1_reg  <= is_signed;
            ll1_reg <= a[H-1:0] * b[H-1:0];
            lh1_reg <= a[H-1:0] * b[DATA_W-1:H];
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            s2_reg  <= s1_reg;
            ll2_reg <= ll1_reg;
            lh2_reg <= lh1_reg;
            hl2_reg <= a1_reg[DATA_W-1:H] * b1_reg[H-1:0];
            hh2_reg <= a1_reg[DATA_W-1:H] * b1_reg[DATA_W-1:H];
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            s3_reg  <= s2_reg;
            hi3_reg <= hi_next;
            hi4_reg <= hi4_next;
        end
    end

    assign high = hi4_reg;
endmodule

@@ sv/iadmb_misc.sv @@
// Shifts, zero counts, redundant sign counts and population counts.
`timescale 1ns / 1ps
module iadmb_misc (
    input  iadmb_pkg::req_t              req,
    output logic [iadmb_pkg::DATA_W-1:0] value
);
    import iadmb_pkg::*;

    function automatic logic [6:0] lead_zeros(input logic [DATA_W-1:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (x[i])
            begin
                n = 7'(DATA_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] trail_zeros(input logic [DATA_W-1:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = DATA_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                n = 7'(i);
            end
        end
        return n;
    endfunction

    logic [31:0]       a32;
    logic [31:0]       b32;
    logic [5:0]        sh;
    logic [31:0]       rs32;
    logic [DATA_W-1:0] rs64;

    always_comb
    begin
        a32  = req.operand_a[31:0];
        b32  = req.operand_b[31:0];
        sh   = req.operand_b[5:0];
        rs32 = a32 ^ {32{a32[31]}};
        rs64 = req.operand_a ^ {DATA_W{req.operand_a[DATA_W-1]}};
        case (req.opcode)
            OP_SHL:      value = req.operand_a << sh;
            OP_SHR:      value = req.operand_a >> sh;
            OP_SAR:      value = DATA_W'($signed(req.operand_a) >>> sh);
            OP_CLZ32:    value = (a32 != 32'd0)
                               ? {57'd0, lead_zeros({a32, 32'hFFFF_FFFF})}
                               : {32'd0, b32};
            OP_CTZ32:    value = (a32 != 32'd0)
                               ? {57'd0, trail_zeros({32'd1, a32})}
                               : {32'd0, b32};
            OP_CLZ64:    value = (req.operand_a != '0)
                               ? {57'd0, lead_zeros(req.operand_a)} : req.operand_b;
            OP_CTZ64:    value = (req.operand_a != '0)
                               ? {57'd0, trail_zeros(req.operand_a)} : req.operand_b;
            OP_CLRSB32:  value = {57'd0, lead_zeros({rs32, 32'hFFFF_FFFF}) - 7'd1};
            OP_CLRSB64:  value = {57'd0, lead_zeros(rs64) - 7'd1};
            OP_POPCNT32: value = {57'd0, 7'($countones(a32))};
            OP_POPCNT64: value = {57'd0, 7'($countones(req.operand_a))};
            default:     value = '0;
        endcase
    end
endmodule

@@ sv/integer_alu_div_mulh_bitcount_unit.sv @@
// Top level of the pipelined integer ALU with divide, multiply-high and bit counts.
`timescale 1ns / 1ps
// This unit takes one request transfer per clock unless stalled and returns
// one response transfer per request, in order, after the request passes
// through an input register, an operand preparation stage, 64 stages of a
// restoring divider (one quotient bit each, a 65-bit subtract per stage), and
// the output register. Every operation runs through the same depth; the
// multiply-high path has four stages of its own and waits in a delay line to
// meet the divider. The pipeline moves as one: whenever the output register
// holds a response that the far side stalls, the whole pipeline holds and
// req_stall is raised, otherwise a new request is taken in every cycle.
// Signed division rounds towards zero; a zero divisor gives all ones as the
// quotient, the dividend as the remainder and raises divide_by_zero. The
// 32-bit operations use the low halves of the operands and return a
// zero-extended result. Reset clears the valid bits only.
module integer_alu_div_mulh_bitcount_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  iadmb_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output iadmb_pkg::rsp_t rsp
);
    import iadmb_pkg::*;

    localparam int MUL_DELAY = DIV_STEPS + 1 - MUL_LAT;

    logic              en;
    logic              s0_valid_reg;
    req_t              s0_req_reg;
    logic              prep_valid_reg;
    div_t              prep_div_reg;
    tag_t              prep_tag_reg;
    div_t              prep_div_next;
    tag_t              prep_tag_next;
    logic [DATA_W-1:0] misc_value;
    logic [DATA_W-1:0] mul_high;
    logic              step_valid [0:DIV_STEPS];
    div_t              step_div [0:DIV_STEPS];
    tag_t              tag_reg [0:DIV_STEPS-1];
    logic [DATA_W-1:0] mul_delay_reg [0:MUL_DELAY-1];
    logic              out_valid_reg;
    rsp_t              out_rsp_reg;
    rsp_t              out_rsp_next;

    // The pipeline advances unless a finished response is being held back.
    assign en        = !(out_valid_reg && rsp_stall);
    assign req_stall = !en;

    iadmb_misc u_misc (
        .req   (s0_req_reg),
        .value (misc_value)
    );

    iadmb_mul u_mul (
        .clk       (clk),
        .en        (en),
        .a         (s0_req_reg.operand_a),
        .b         (s0_req_reg.operand_b),
        .is_signed (s0_req_reg.opcode == OP_MULHS),
        .high      (mul_high)
    );

    // Operand preparation: width, signs, magnitudes and the zero-divisor case.
    always_comb
    begin
        logic              is32;
        logic              is_div;
        logic              is_signed;
        logic              want_rem;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] am;
        logic [DATA_W-1:0] bm;
        logic              na;
        logic              nb;
        is32      = 1'b0;
        is_div    = 1'b1;
        is_signed = 1'b0;
        want_rem  = 1'b0;
        case (s0_req_reg.opcode)
            OP_DIV32:  begin is32 = 1'b1; is_signed = 1'b1; end
            OP_REM32:  begin is32 = 1'b1; is_signed = 1'b1; want_rem = 1'b1; end
            OP_DIVU32: begin is32 = 1'b1; end
            OP_REMU32: begin is32 = 1'b1; want_rem = 1'b1; end
            OP_DIV64:  begin is_signed = 1'b1; end
            OP_REM64:  begin is_signed = 1'b1; want_rem = 1'b1; end
            OP_DIVU64: begin end
            OP_REMU64: begin want_rem = 1'b1; end
            default:   begin is_div = 1'b0; end
        endcase
        mask = is32 ? {32'd0, 32'hFFFF_FFFF} : '1;
        am   = s0_req_reg.operand_a & mask;
        bm   = s0_req_reg.operand_b & mask;
        na   = is_signed && (is32 ? am[31] : am[DATA_W-1]);
        nb   = is_signed && (is32 ? bm[31] : bm[DATA_W-1]);

        prep_div_next.rem = '0;
        prep_div_next.dq  = na ? ((DATA_W'(0) - am) & mask) : am;
        prep_div_next.d   = nb ? ((DATA_W'(0) - bm) & mask) : bm;

        prep_tag_next.neg_q = na != nb;
        prep_tag_next.neg_r = na;
        prep_tag_next.is32  = is32;
        prep_tag_next.dz    = is_div && (bm == '0);
        prep_tag_next.misc  = misc_value;
        if (!is_div)
        begin
            prep_tag_next.sel = (s0_req_reg.opcode == OP_MULHU ||
                                 s0_req_reg.opcode == OP_MULHS) ? SEL_MUL : SEL_MISC;
        end
        else if (bm == '0)
        begin
            prep_tag_next.sel  = SEL_MISC;
            prep_tag_next.misc = want_rem ? am : mask;
        end
        else
        begin
            prep_tag_next.sel = want_rem ? SEL_REM : SEL_QUO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg   <= req_valid;
            prep_valid_reg <= s0_valid_reg;
            out_valid_reg  <= step_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_req_reg   <= req;
            prep_div_reg <= prep_div_next;
            prep_tag_reg <= prep_tag_next;
            out_rsp_reg  <= out_rsp_next;
        end
    end

    assign step_valid[0] = prep_valid_reg;
    assign step_div[0]   = prep_div_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_step
            iadmb_div_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (step_valid[gi]),
                .in_div    (step_div[gi]),
                .out_valid (step_valid[gi+1]),
                .out_div   (step_div[gi+1])
            );
        end
    endgenerate

    // Control and multiply results travel beside the divider stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0]       <= prep_tag_reg;
            mul_delay_reg[0] <= mul_high;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            for (int i = 1; i < MUL_DELAY; i++)
            begin
                mul_delay_reg[i] <= mul_delay_reg[i-1];
            end
        end
    end

    // Sign fix-up, result selection and narrowing of 32-bit results.
    always_comb
    begin
        tag_t              t;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rmd;
        logic [DATA_W-1:0] res;
        t   = tag_reg[DIV_STEPS-1];
        quo = t.neg_q ? (DATA_W'(0) - step_div[DIV_STEPS].dq) : step_div[DIV_STEPS].dq;
        rmd = t.neg_r ? (DATA_W'(0) - step_div[DIV_STEPS].rem) : step_div[DIV_STEPS].rem;
        case (t.sel)
            SEL_QUO: res = quo;
            SEL_REM: res = rmd;
            SEL_MUL: res = mul_delay_reg[MUL_DELAY-1];
            default: res = t.misc;
        endcase
        out_rsp_next.result         = t.is32 ? {32'd0, res[31:0]} : res;
        out_rsp_next.divide_by_zero = t.dz;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;
endmodule

@@ sv/iadmb_checker.sv @@
// Port-level checker for the integer ALU and its bind to the top level.
`timescale 1ns / 1ps
`include "integer_alu_div_mulh_bitcount_unit_assert.svh"
module iadmb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input iadmb_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input iadmb_pkg::rsp_t rsp
);
    import iadmb_pkg::*;

    // A stalled request holds its valid and payload.
    `IADMB_ASSERT(a_req_hold, clk, rst_n, req_valid && req_stall |=> req_valid && $stable(req))
    // A stalled response holds its valid and payload.
    `IADMB_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    // Requests are held back exactly when a response is held back.
    `IADMB_ASSERT(a_stall_link, clk, rst_n, req_stall == (rsp_valid && rsp_stall))
    // Reset leaves no response behind.
    `IADMB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !rsp_valid)
endmodule

bind integer_alu_div_mulh_bitcount_unit iadmb_checker u_iadmb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
